FILE: src/ket_pkg.sv
// ----------------------------------------------------------------------------
// ket_pkg: shared types and constants of the keyed extent table
// Field structs, status codes, table geometry and sequencer states.
// ----------------------------------------------------------------------------
package ket_pkg;

  localparam int ENTRIES     = 64;
  localparam int IDX_W       = $clog2(ENTRIES);
  localparam int OFFSET_BITS = 48;
  localparam int EXT_W       = OFFSET_BITS + 1;
  localparam logic [63:0] RESERVED_UPPER = 64'hEFEF_EFEF_EFEF_EFEF;
  localparam logic [63:0] RESERVED_LOWER = 64'hFEFE_FEFE_FEFE_FEFE;
  localparam logic [31:0] TABLE_BYTES_RST = 32'd1024;

  localparam logic [1:0] FUNC_ADD = 2'd0;
  localparam logic [1:0] FUNC_DEL = 2'd1;
  localparam logic [1:0] FUNC_LKP = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_RESERVED  = 3'd3;
  localparam logic [2:0] ST_OVERFLOW  = 3'd4;

  typedef struct packed {
    logic [1:0]  func;
    logic [63:0] name_high;
    logic [63:0] name_low;
    logic [30:0] length;
    logic        compressed;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [5:0]  slot;
    logic [47:0] offset;
    logic [30:0] stored_length;
    logic        stored_compressed;
    logic [5:0]  file_count;
  } out_beat_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_PLACE,
    S_READ,
    S_WRITE,
    S_DONE
  } seq_state_t;

endpackage

FILE: src/keyed_extent_table_first_fit_top.sv
// ----------------------------------------------------------------------------
// keyed_extent_table_first_fit_top
// Channel | dir | handshake          | payload
// in_     | in  | in_valid/in_stall  | ket_pkg::in_beat_t
// out_    | out | out_valid/out_stall| ket_pkg::out_beat_t
// cfg_    | in  | cfg_we             | cfg_wdata (table extent bytes)
// One beat at a time. Search sweeps all ENTRIES entries through the one table
// read port. An add then runs first-fit passes on the shared comparator: a
// pass that jumps restarts from entry 0, a clean pass ends it, at most ENTRIES
// jumps. Lookup goes through S_READ and S_WRITE, add/delete through S_WRITE,
// and S_DONE then presents the result beat. Reset is synchronous; entry 0 comes
// up reserved. in_stall holds until the result beat is taken.
// ----------------------------------------------------------------------------
module keyed_extent_table_first_fit_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ket_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output ket_pkg::out_beat_t out_data,
  input  logic               cfg_we,
  input  logic [31:0]        cfg_wdata
);

  localparam int IW = ket_pkg::IDX_W;
  localparam int OB = ket_pkg::OFFSET_BITS;
  localparam int EW = ket_pkg::EXT_W;

  ket_pkg::seq_state_t state_r, state_nxt;
  ket_pkg::in_beat_t   req_r;
  ket_pkg::out_beat_t  res_r, res_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [IW:0]         cnt_r, cnt_nxt;       // read address stream
  logic [IW:0]         chk_r, chk_nxt;       // entry being judged
  logic [IW-1:0]       hit_r, hit_nxt, free_r, free_nxt;
  logic                has_hit_r, has_hit_nxt, has_free_r, has_free_nxt;
  logic [EW-1:0]       cand_r, cand_nxt;
  logic                coll_r, coll_nxt;
  logic [5:0]          used_cnt_r, used_cnt_nxt;

  logic [63:0]         rd_upper, rd_lower;
  logic [OB-1:0]       rd_start;
  logic [31:0]         rd_len;
  logic                rd_cmp, rd_used;
  logic                wr_en, wr_free;
  logic [IW-1:0]       rd_idx;

  ket_table u_table (
    .clk, .rst_n,
    .rd_idx, .rd_upper, .rd_lower, .rd_start, .rd_len, .rd_cmp, .rd_used,
    .wr_en, .wr_free,
    .wr_idx   (has_hit_r ? hit_r : free_r),
    .wr_upper (wr_free ? 64'd0 : req_r.name_high),
    .wr_lower (wr_free ? 64'd0 : req_r.name_low),
    .wr_start (wr_free ? '0 : cand_r[OB-1:0]),
    .wr_len   (wr_free ? 32'd0 : {1'b0, req_r.length}),
    .wr_cmp   (wr_free ? 1'b0 : req_r.compressed),
    .len0_en  (cfg_we),
    .len0_val (cfg_wdata)
  );

  // entry 0 lives in flops inside the table; read path still through port
  assign rd_idx = cnt_r[IW-1:0];

  logic is_zero, is_res, key_eq;
  assign is_zero = (req_r.name_high == '0) && (req_r.name_low == '0);
  assign is_res  = (req_r.name_high == ket_pkg::RESERVED_UPPER) &&
                   (req_r.name_low == ket_pkg::RESERVED_LOWER);
  assign key_eq  = rd_used && (rd_upper == req_r.name_high) &&
                   (rd_lower == req_r.name_low);

  // shared extent comparator
  logic [EW-1:0] e_end, c_end;
  logic          hit_now;
  assign e_end   = EW'(rd_start) + EW'(rd_len);
  assign c_end   = cand_r + EW'(req_r.length);
  assign hit_now = rd_used && (c_end >= EW'(rd_start)) && (cand_r < e_end);

  assign in_stall  = (state_r != ket_pkg::S_IDLE) || out_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ket_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      used_cnt_r  <= '0;
      cnt_r       <= '0;
      chk_r       <= '0;
      has_hit_r   <= 1'b0;
      has_free_r  <= 1'b0;
      coll_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      used_cnt_r  <= used_cnt_nxt;
      cnt_r       <= cnt_nxt;
      chk_r       <= chk_nxt;
      has_hit_r   <= has_hit_nxt;
      has_free_r  <= has_free_nxt;
      coll_r      <= coll_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      req_r <= in_data;
    end
    res_r  <= res_nxt;
    hit_r  <= hit_nxt;
    free_r <= free_nxt;
    cand_r <= cand_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    res_nxt       = res_r;
    cnt_nxt       = cnt_r;
    chk_nxt       = chk_r;
    hit_nxt       = hit_r;
    free_nxt      = free_r;
    has_hit_nxt   = has_hit_r;
    has_free_nxt  = has_free_r;
    cand_nxt      = cand_r;
    coll_nxt      = coll_r;
    used_cnt_nxt  = used_cnt_r;
    wr_en         = 1'b0;
    wr_free       = 1'b0;
    unique case (state_r)
      ket_pkg::S_IDLE: begin
        if (in_valid && !in_stall) begin
          state_nxt    = ket_pkg::S_SEARCH;
          cnt_nxt      = (IW+1)'(1);
          chk_nxt      = '0;
          has_hit_nxt  = 1'b0;
          has_free_nxt = 1'b0;
        end
      end
      ket_pkg::S_SEARCH: begin
        // data for entry chk_r is on the read port
        if (key_eq && !has_hit_r) begin
          has_hit_nxt = 1'b1;
          hit_nxt     = chk_r[IW-1:0];
        end
        if (!rd_used && !has_free_r) begin
          has_free_nxt = 1'b1;
          free_nxt     = chk_r[IW-1:0];
        end
        cnt_nxt = cnt_r + 1'b1;
        chk_nxt = chk_r + 1'b1;
        if (chk_r == (IW+1)'(ket_pkg::ENTRIES - 1)) begin
          state_nxt = ket_pkg::S_DONE;
          cnt_nxt   = '0;
          res_nxt   = '0;
          res_nxt.status = ket_pkg::ST_NOT_FOUND;
          if (req_r.func == ket_pkg::FUNC_ADD) begin
            if (is_zero) begin
              res_nxt.status = ket_pkg::ST_RESERVED;
            end else if (!has_hit_nxt && !has_free_nxt) begin
              res_nxt.status = ket_pkg::ST_FULL;
            end else begin
              state_nxt = ket_pkg::S_PLACE;
              cnt_nxt   = (IW+1)'(1);
              chk_nxt   = '0;
              cand_nxt  = '0;
              coll_nxt  = 1'b0;
            end
          end else if (req_r.func == ket_pkg::FUNC_DEL) begin
            if (is_res) begin
              res_nxt.status = ket_pkg::ST_RESERVED;
            end else if (!is_zero && has_hit_nxt) begin
              state_nxt = ket_pkg::S_WRITE;
            end
          end else if (req_r.func == ket_pkg::FUNC_LKP) begin
            if (!is_zero && has_hit_nxt) begin
              state_nxt = ket_pkg::S_READ;
              cnt_nxt   = {1'b0, hit_nxt};
            end
          end
        end
      end
      ket_pkg::S_READ: begin
        state_nxt = ket_pkg::S_WRITE;
      end
      ket_pkg::S_PLACE: begin
        // one entry per cycle until a jump; after a jump the coll_r step refetches entry 0
        if (coll_r) begin
          coll_nxt = 1'b0;
          cnt_nxt  = (IW+1)'(1);
          chk_nxt  = '0;
        end else if (hit_now) begin
          coll_nxt = 1'b1;
          cand_nxt = e_end;
          cnt_nxt  = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
          chk_nxt = chk_r + 1'b1;
          if (chk_r == (IW+1)'(ket_pkg::ENTRIES - 1)) begin
            state_nxt = ket_pkg::S_WRITE;
          end
        end
      end
      ket_pkg::S_WRITE: begin
        state_nxt = ket_pkg::S_DONE;
        res_nxt   = '0;
        res_nxt.file_count = used_cnt_r;
        if (req_r.func == ket_pkg::FUNC_DEL) begin
          wr_en   = 1'b1;
          wr_free = 1'b1;
          if (used_cnt_r != '0) begin
            used_cnt_nxt = used_cnt_r - 1'b1;
          end
          res_nxt.slot = hit_r;
        end else if (req_r.func == ket_pkg::FUNC_LKP) begin
          res_nxt.slot              = hit_r;
          res_nxt.offset            = rd_start;
          res_nxt.stored_length     = rd_len[30:0];
          res_nxt.stored_compressed = rd_cmp;
        end else if (cand_r[OB] || c_end > (EW'(1) << OB)) begin
          res_nxt.status = ket_pkg::ST_OVERFLOW;
        end else begin
          wr_en = 1'b1;
          if (!has_hit_r && !is_res) begin
            used_cnt_nxt = used_cnt_r + 1'b1;
          end
          res_nxt.slot              = has_hit_r ? hit_r : free_r;
          res_nxt.offset            = cand_r[OB-1:0];
          res_nxt.stored_length     = req_r.length;
          res_nxt.stored_compressed = req_r.compressed;
        end
      end
      ket_pkg::S_DONE: begin
        res_nxt.file_count = used_cnt_r;
        out_valid_nxt = 1'b1;
        cnt_nxt       = '0;
        state_nxt     = ket_pkg::S_IDLE;
      end
      default: state_nxt = ket_pkg::S_IDLE;
    endcase
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ket_pkg::S_IDLE |-> in_stall)
    else $error("beat accepted while busy");
  a_done_valid: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ket_pkg::S_DONE |=> out_valid)
    else $error("result not presented");
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ket_pkg::S_WRITE && wr_en && !wr_free && !has_hit_r && !is_res)
      |=> used_cnt_r == $past(used_cnt_r) + 6'd1)
    else $error("file count not advanced");

endmodule

FILE: src/ket_table.sv
// ----------------------------------------------------------------------------
// ket_table: entry storage
// Key, extent and mark per entry; one read port (registered), one write port.
// Used bit per entry, reset clears all but entry 0.
// ----------------------------------------------------------------------------
module ket_table (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [ket_pkg::IDX_W-1:0]    rd_idx,
  output logic [63:0]                  rd_upper,
  output logic [63:0]                  rd_lower,
  output logic [ket_pkg::OFFSET_BITS-1:0] rd_start,
  output logic [31:0]                  rd_len,
  output logic                         rd_cmp,
  output logic                         rd_used,
  input  logic                         wr_en,
  input  logic                         wr_free,
  input  logic [ket_pkg::IDX_W-1:0]    wr_idx,
  input  logic [63:0]                  wr_upper,
  input  logic [63:0]                  wr_lower,
  input  logic [ket_pkg::OFFSET_BITS-1:0] wr_start,
  input  logic [31:0]                  wr_len,
  input  logic                         wr_cmp,
  input  logic                         len0_en,
  input  logic [31:0]                  len0_val
);

  logic [63:0] upper_mem [ket_pkg::ENTRIES];
  logic [63:0] lower_mem [ket_pkg::ENTRIES];
  logic [ket_pkg::OFFSET_BITS-1:0] start_mem [ket_pkg::ENTRIES];
  logic [31:0] len_mem   [ket_pkg::ENTRIES];
  logic        cmp_mem   [ket_pkg::ENTRIES];
  logic [ket_pkg::ENTRIES-1:0] used_r;
  logic [31:0] len0_r;

  // entry 0 is kept in flops so that reset and config writes land at once
  logic [63:0] up0_r, lo0_r;
  logic [ket_pkg::OFFSET_BITS-1:0] st0_r;
  logic        cm0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= {{(ket_pkg::ENTRIES-1){1'b0}}, 1'b1};
      up0_r  <= ket_pkg::RESERVED_UPPER;
      lo0_r  <= ket_pkg::RESERVED_LOWER;
      st0_r  <= '0;
      cm0_r  <= 1'b0;
      len0_r <= ket_pkg::TABLE_BYTES_RST;
    end else begin
      if (len0_en) begin
        len0_r <= len0_val;
      end
      if (wr_en) begin
        used_r[wr_idx] <= !wr_free;
        if (wr_idx == '0) begin
          up0_r <= wr_upper;
          lo0_r <= wr_lower;
          st0_r <= wr_start;
          cm0_r <= wr_cmp;
          len0_r <= wr_len;
        end
      end
    end
  end

  // entry 0 is served from its flops, the rest from the arrays
  always_ff @(posedge clk) begin
    if (wr_en) begin
      upper_mem[wr_idx] <= wr_upper;
      lower_mem[wr_idx] <= wr_lower;
      start_mem[wr_idx] <= wr_start;
      len_mem[wr_idx]   <= wr_len;
      cmp_mem[wr_idx]   <= wr_cmp;
    end
    if (rd_idx == '0) begin
      rd_upper <= up0_r;
      rd_lower <= lo0_r;
      rd_start <= st0_r;
      rd_len   <= len0_r;
      rd_cmp   <= cm0_r;
    end else begin
      rd_upper <= upper_mem[rd_idx];
      rd_lower <= lower_mem[rd_idx];
      rd_start <= start_mem[rd_idx];
      rd_len   <= len_mem[rd_idx];
      rd_cmp   <= cmp_mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_used <= 1'b0;
    end else begin
      rd_used <= used_r[rd_idx];
    end
  end

endmodule
